// ----- hw/rtl/yuv2rgb_pkg.sv -----
package yuv2rgb_pkg;

	localparam int PaddrW = 4;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t RegColorMatrix  = 2'd0;
	localparam reg_idx_t RegChromaOrder  = 2'd1;
	localparam reg_idx_t RegChannelOrder = 2'd2;

	typedef logic signed [11:0] gain_t;
	typedef logic signed [12:0] coef_t;
	typedef logic signed [20:0] prod_t;
	typedef logic signed [22:0] acc_t;

	localparam logic [7:0] LumaOfs = 8'd16;
	localparam gain_t YGain  = 12'sd1192;
	localparam acc_t  RndBias = 23'sd512;

	localparam coef_t CoefRv601 = 13'sd1634;
	localparam coef_t CoefGu601 = -13'sd401;
	localparam coef_t CoefGv601 = -13'sd833;
	localparam coef_t CoefBu601 = 13'sd2065;
	localparam coef_t CoefRv709 = 13'sd1836;
	localparam coef_t CoefGu709 = -13'sd218;
	localparam coef_t CoefGv709 = -13'sd546;
	localparam coef_t CoefBu709 = 13'sd2166;

	localparam logic [7:0] Alpha = 8'hff;

	// floor shift by 10 and clamp to 0..255
	function automatic logic [7:0] sat_chan(input acc_t s);
		logic [7:0] res;
		if (s[22]) begin
			res = 8'd0;
		end else if (|s[21:18]) begin
			res = 8'd255;
		end else begin
			res = s[17:10];
		end
		return res;
	endfunction

	function automatic logic [31:0] pack_pix(input logic rgba, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		logic [31:0] res;
		if (rgba) begin
			res = {Alpha, b, g, r};
		end else begin
			res = {Alpha, r, g, b};
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/yuv420_to_rgba_pixel_pair_top.sv -----
// Converts one 4:2:0 pixel pair (two luma bytes sharing one chroma pair) per clock, while
// the output is not stalled, from limited-range BT.601 or BT.709 YCbCr to packed BGRA or
// RGBA. Four register stages (input capture, multiply, sum, clamp and pack into the output
// register) carry the pair from the input transfer to the result being shown; a new pair is
// taken every cycle while the output is not stalled, and each stage keeps moving into free
// space ahead of it while the output waits. Registers are read by the pipeline directly, so
// write them only while no pair is in flight.
module yuv420_to_rgba_pixel_pair_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [yuv2rgb_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           pair_valid,
	output logic                           pair_ready,
	input  logic [7:0]                     luma_first,
	input  logic [7:0]                     luma_second,
	input  logic [7:0]                     chroma_first,
	input  logic [7:0]                     chroma_second,
	input  logic                           second_valid,
	output logic                           pixel_valid,
	input  logic                           pixel_ready,
	output logic [31:0]                    pixel_first,
	output logic [31:0]                    pixel_second,
	output logic                           second_present
);
	import yuv2rgb_pkg::*;

	logic color_matrix_q, chroma_order_q, channel_order_q;
	reg_idx_t idx;
	logic wr_en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	logic signed [8:0] yd0_s1, yd1_s1;
	logic signed [7:0] u_s1, vc_s1;
	logic sec_s1;

	prod_t yy0_s2, yy1_s2, prv_s2, pgu_s2, pgv_s2, pbu_s2;
	logic sec_s2;

	acc_t r0_s3, g0_s3, b0_s3, r1_s3, g1_s3, b1_s3;
	logic sec_s3;

	logic [31:0] pix0_s4, pix1_s4;
	logic sec_s4;

	coef_t c_rv, c_gu, c_gv, c_bu;
	logic signed [7:0] cf, cs;

	// configuration port
	assign pready = 1'b1;
	assign idx    = paddr[PaddrW-1:2];
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_matrix_q  <= 1'b0;
			chroma_order_q  <= 1'b0;
			channel_order_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				RegColorMatrix:  color_matrix_q  <= pwdata[0];
				RegChromaOrder:  chroma_order_q  <= pwdata[0];
				RegChannelOrder: channel_order_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegColorMatrix:  prdata = {31'd0, color_matrix_q};
			RegChromaOrder:  prdata = {31'd0, chroma_order_q};
			RegChannelOrder: prdata = {31'd0, channel_order_q};
			default:         prdata = 32'd0;
		endcase
	end

	// pipeline flow control
	assign ld4        = !v_s4 || pixel_ready;
	assign ld3        = !v_s3 || ld4;
	assign ld2        = !v_s2 || ld3;
	assign ld1        = !v_s1 || ld2;
	assign pair_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= pair_valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// chroma offset removal
	assign cf = $signed({~chroma_first[7], chroma_first[6:0]});
	assign cs = $signed({~chroma_second[7], chroma_second[6:0]});

	always_comb begin
		if (color_matrix_q) begin
			c_rv = CoefRv709;
			c_gu = CoefGu709;
			c_gv = CoefGv709;
			c_bu = CoefBu709;
		end else begin
			c_rv = CoefRv601;
			c_gu = CoefGu601;
			c_gv = CoefGv601;
			c_bu = CoefBu601;
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (ld1 && pair_valid) begin
			yd0_s1 <= $signed({1'b0, luma_first}) - $signed({1'b0, LumaOfs});
			yd1_s1 <= $signed({1'b0, luma_second}) - $signed({1'b0, LumaOfs});
			u_s1   <= chroma_order_q ? cs : cf;
			vc_s1  <= chroma_order_q ? cf : cs;
			sec_s1 <= second_valid;
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			yy0_s2 <= yd0_s1 * YGain;
			yy1_s2 <= yd1_s1 * YGain;
			prv_s2 <= c_rv * vc_s1;
			pgu_s2 <= c_gu * u_s1;
			pgv_s2 <= c_gv * vc_s1;
			pbu_s2 <= c_bu * u_s1;
			sec_s2 <= sec_s1;
		end
	end

	// stage 3: sums with rounding bias
	always_ff @(posedge clk) begin
		if (ld3 && v_s2) begin
			r0_s3  <= acc_t'(yy0_s2) + acc_t'(prv_s2) + RndBias;
			g0_s3  <= acc_t'(yy0_s2) + acc_t'(pgu_s2) + acc_t'(pgv_s2) + RndBias;
			b0_s3  <= acc_t'(yy0_s2) + acc_t'(pbu_s2) + RndBias;
			r1_s3  <= acc_t'(yy1_s2) + acc_t'(prv_s2) + RndBias;
			g1_s3  <= acc_t'(yy1_s2) + acc_t'(pgu_s2) + acc_t'(pgv_s2) + RndBias;
			b1_s3  <= acc_t'(yy1_s2) + acc_t'(pbu_s2) + RndBias;
			sec_s3 <= sec_s2;
		end
	end

	// stage 4: clamp and pack into the output register
	always_ff @(posedge clk) begin
		if (ld4 && v_s3) begin
			pix0_s4 <= pack_pix(channel_order_q, sat_chan(r0_s3), sat_chan(g0_s3),
				sat_chan(b0_s3));
			pix1_s4 <= sec_s3 ? pack_pix(channel_order_q, sat_chan(r1_s3), sat_chan(g1_s3),
				sat_chan(b1_s3)) : 32'd0;
			sec_s4  <= sec_s3;
		end
	end

	assign pixel_valid    = v_s4;
	assign pixel_first    = pix0_s4;
	assign pixel_second   = pix1_s4;
	assign second_present = sec_s4;

endmodule
